// ===== sv/keyed_record_stream_parser_top_macros.svh =====
// assertion macros for the snapshot parser rtl
// expects clk and rst_n in the scope of each use
`ifndef KEYED_RECORD_STREAM_PARSER_TOP_MACROS_SVH
`define KEYED_RECORD_STREAM_PARSER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define KRSP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define KRSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/krsp_pkg.sv =====
// types and constants for the keyed record snapshot parser
// no dependencies
`timescale 1ns / 1ps

package krsp_pkg;

    localparam int SIG_LEN = 11;
    localparam int SIG_POS_BITS = 4;

    // file signature bytes
    localparam logic [7:0] SIG_TABLE [SIG_LEN] = '{
        8'h46, 8'h4F, 8'h55, 8'h52, 8'h2D, 8'h46, 8'h41, 8'h49, 8'h54, 8'h48, 8'h3A
    };

    // byte classes
    localparam logic [2:0] CLS_SIG  = 3'd0;
    localparam logic [2:0] CLS_VER  = 3'd1;
    localparam logic [2:0] CLS_KLEN = 3'd2;
    localparam logic [2:0] CLS_KEY  = 3'd3;
    localparam logic [2:0] CLS_VLO  = 3'd4;
    localparam logic [2:0] CLS_VHI  = 3'd5;
    localparam logic [2:0] CLS_VAL  = 3'd6;
    localparam logic [2:0] CLS_IGN  = 3'd7;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SIG   = 3'd1;
    localparam logic [2:0] ST_NO_VER    = 3'd2;
    localparam logic [2:0] ST_EMPTY_KEY = 3'd3;
    localparam logic [2:0] ST_KEY_CUT   = 3'd4;
    localparam logic [2:0] ST_VAL_CUT   = 3'd5;
    localparam logic [2:0] ST_BAD_CHAR  = 3'd6;
    localparam logic [2:0] ST_NO_RECS   = 3'd7;

    typedef enum logic [7:0] {
        PH_SIG  = 8'b0000_0001,
        PH_VER  = 8'b0000_0010,
        PH_KLEN = 8'b0000_0100,
        PH_KEY  = 8'b0000_1000,
        PH_VLO  = 8'b0001_0000,
        PH_VHI  = 8'b0010_0000,
        PH_VAL  = 8'b0100_0000,
        PH_IGN  = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [2:0]  byte_class;
        logic [7:0]  echo_byte;
        logic [15:0] record_index;
        logic        record_end;
        logic        stream_done;
        logic [2:0]  status_code;
        logic [15:0] good_records;
        logic [7:0]  format_version;
    } result_item_t;

    // letters, digits, underscore, dot, dash
    function automatic logic key_char_ok(input logic [7:0] c);
        return (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39], 8'h5F, 8'h2E, 8'h2D});
    endfunction

endpackage

// ===== sv/krsp_core.sv =====
// parser state and per-byte classification for the snapshot parser
// depends on krsp_pkg and keyed_record_stream_parser_top_macros.svh
`timescale 1ns / 1ps
`include "keyed_record_stream_parser_top_macros.svh"

module krsp_core
    import krsp_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_fire,
    input  byte_item_t   in_item,
    output result_item_t result
);

    phase_t                  phase_reg, phase_next;
    logic [SIG_POS_BITS-1:0] sig_pos_reg, sig_pos_next;
    logic [7:0]              key_left_reg, key_left_next;
    logic [15:0]             value_left_reg, value_left_next;
    logic [7:0]              length_low_reg, length_low_next;
    logic                    key_bad_reg, key_bad_next;
    logic [COUNT_BITS-1:0]   total_reg, total_next;
    logic [7:0]              version_reg, version_next;
    logic [2:0]              error_reg, error_next;

    logic [2:0]  cls;
    logic        complete;
    logic        rec_end;
    logic [2:0]  status;
    logic [7:0]  b;
    logic        last;
    logic [15:0] vlen;

    assign b    = in_item.data_byte;
    assign last = in_item.last_byte;
    assign vlen = {b, length_low_reg};

    always_comb
    begin
        phase_next      = phase_reg;
        sig_pos_next    = sig_pos_reg;
        key_left_next   = key_left_reg;
        value_left_next = value_left_reg;
        length_low_next = length_low_reg;
        key_bad_next    = key_bad_reg;
        total_next      = total_reg;
        version_next    = version_reg;
        error_next      = error_reg;
        cls             = CLS_IGN;
        complete        = 1'b0;
        rec_end         = 1'b0;

        case (phase_reg)
            PH_SIG:
            begin
                cls = CLS_SIG;
                if ((32'(sig_pos_reg) >= SIG_LEN) || (b != SIG_TABLE[sig_pos_reg]))
                begin
                    error_next = ST_BAD_SIG;
                    phase_next = PH_IGN;
                end
                else if (32'(sig_pos_reg) == SIG_LEN - 1)
                begin
                    sig_pos_next = '0;
                    phase_next   = PH_VER;
                    if (last)
                    begin
                        error_next = ST_NO_VER;
                        phase_next = PH_IGN;
                    end
                end
                else
                begin
                    sig_pos_next = sig_pos_reg + 1'b1;
                    if (last)
                    begin
                        error_next = ST_BAD_SIG;
                        phase_next = PH_IGN;
                    end
                end
            end
            PH_VER:
            begin
                cls          = CLS_VER;
                version_next = b;
                phase_next   = PH_KLEN;
            end
            PH_KLEN:
            begin
                cls = CLS_KLEN;
                if (b == 8'd0)
                begin
                    error_next = ST_EMPTY_KEY;
                    phase_next = PH_IGN;
                end
                else
                begin
                    key_left_next = b;
                    key_bad_next  = 1'b0;
                    phase_next    = PH_KEY;
                    if (last)
                    begin
                        error_next = ST_KEY_CUT;
                        phase_next = PH_IGN;
                    end
                end
            end
            PH_KEY:
            begin
                cls = CLS_KEY;
                if (!key_char_ok(b))
                begin
                    key_bad_next = 1'b1;
                end
                key_left_next = key_left_reg - 1'b1;
                if (key_left_reg == 8'd1)
                begin
                    phase_next = PH_VLO;
                end
                if (last)
                begin
                    error_next = ST_KEY_CUT;
                    phase_next = PH_IGN;
                end
            end
            PH_VLO:
            begin
                cls             = CLS_VLO;
                length_low_next = b;
                phase_next      = PH_VHI;
                if (last)
                begin
                    error_next = ST_KEY_CUT;
                    phase_next = PH_IGN;
                end
            end
            PH_VHI:
            begin
                cls             = CLS_VHI;
                value_left_next = vlen;
                if (vlen == 16'd0)
                begin
                    complete = 1'b1;
                end
                else
                begin
                    phase_next = PH_VAL;
                    if (last)
                    begin
                        error_next = ST_VAL_CUT;
                        phase_next = PH_IGN;
                    end
                end
            end
            PH_VAL:
            begin
                cls             = CLS_VAL;
                value_left_next = value_left_reg - 1'b1;
                if (value_left_reg == 16'd1)
                begin
                    complete = 1'b1;
                end
                else if (last)
                begin
                    error_next = ST_VAL_CUT;
                    phase_next = PH_IGN;
                end
            end
            PH_IGN:
            begin
                cls = CLS_IGN;
            end
            default:
            begin
                cls        = CLS_IGN;
                phase_next = PH_IGN;
            end
        endcase

        // key charset is judged once the whole record is in
        if (complete)
        begin
            if (key_bad_reg)
            begin
                error_next = ST_BAD_CHAR;
                phase_next = PH_IGN;
            end
            else
            begin
                if (total_reg != '1)
                begin
                    total_next = total_reg + 1'b1;
                end
                rec_end    = 1'b1;
                phase_next = PH_KLEN;
            end
        end

        status = error_next;
        if (last && (error_next == ST_OK) && (total_next == '0))
        begin
            status = ST_NO_RECS;
        end

        result.byte_class     = cls;
        result.echo_byte      = b;
        result.record_index   = 16'(total_reg);
        result.record_end     = rec_end;
        result.stream_done    = last;
        result.status_code    = status;
        result.good_records   = 16'(total_next);
        result.format_version = version_next;

        // the last byte starts the parser over for the next file
        if (last)
        begin
            phase_next      = PH_SIG;
            sig_pos_next    = '0;
            key_left_next   = '0;
            value_left_next = '0;
            length_low_next = '0;
            key_bad_next    = 1'b0;
            total_next      = '0;
            version_next    = '0;
            error_next      = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_SIG;
            sig_pos_reg    <= '0;
            key_left_reg   <= '0;
            value_left_reg <= '0;
            length_low_reg <= '0;
            key_bad_reg    <= 1'b0;
            total_reg      <= '0;
            version_reg    <= '0;
            error_reg      <= ST_OK;
        end
        else if (in_fire)
        begin
            phase_reg      <= phase_next;
            sig_pos_reg    <= sig_pos_next;
            key_left_reg   <= key_left_next;
            value_left_reg <= value_left_next;
            length_low_reg <= length_low_next;
            key_bad_reg    <= key_bad_next;
            total_reg      <= total_next;
            version_reg    <= version_next;
            error_reg      <= error_next;
        end
    end

    `KRSP_ASSERT_NOW(a_err_iff_ign, 1'b1,
        (error_reg != ST_OK) == (phase_reg == PH_IGN),
        "held error and ignore phase disagree")
    `KRSP_ASSERT_NOW(a_end_cls, in_fire && result.record_end,
        (result.byte_class == CLS_VHI) || (result.byte_class == CLS_VAL),
        "record end on a non-value byte")
    `KRSP_ASSERT_NOW(a_end_ok, in_fire && result.record_end,
        result.status_code == ST_OK,
        "record end with error status")
    `KRSP_ASSERT_NEXT(a_last_restart, in_fire && in_item.last_byte,
        (phase_reg == PH_SIG) && (total_reg == '0),
        "parser not restarted after last byte")

endmodule

// ===== sv/krsp_out_stage.sv =====
// result register with valid/ready handshake for the snapshot parser
// depends on krsp_pkg
`timescale 1ns / 1ps

module krsp_out_stage
    import krsp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  result_item_t load_data,
    output logic         can_load,
    output logic         result_valid,
    input  logic         result_ready,
    output result_item_t result_data
);

    logic         valid_reg;
    result_item_t data_reg;

    // a new result may replace one that is taken in the same cycle
    assign can_load     = !valid_reg || result_ready;
    assign result_valid = valid_reg;
    assign result_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

// ===== sv/keyed_record_stream_parser_top.sv =====
// channel      | direction | payload
// byte_*       | in        | byte_item_t   (data_byte, last_byte)
// result_*     | out       | result_item_t (one result per byte)
//
// one byte per clock unless stalled; the result appears in the cycle after the byte transaction
// the parser state advances in the cycle of the transaction, the output register holds the result
// a stalled result holds off new bytes only while the output register is full and not taken
// reset returns the parser to the signature phase with no result pending
// depends on krsp_pkg, krsp_core and krsp_out_stage
`timescale 1ns / 1ps

module keyed_record_stream_parser_top
    import krsp_pkg::*;
#(
    parameter int COUNT_BITS = 16
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         byte_valid,
    output logic         byte_ready,
    input  byte_item_t   byte_data,
    output logic         result_valid,
    input  logic         result_ready,
    output result_item_t result_data
);

    logic         fire;
    logic         can_load;
    result_item_t step_result;

    assign byte_ready = can_load;
    assign fire       = byte_valid && can_load;

    krsp_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (fire),
        .in_item (byte_data),
        .result  (step_result)
    );

    krsp_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire),
        .load_data    (step_result),
        .can_load     (can_load),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

endmodule
